@@ hw/rtl/lcdmt_pkg.sv @@
// ---------------------------------------------------------------------------
// lcdmt_pkg: shared definitions for the display mode timing block
// Mode codes, phase lengths, register indexes and enable bit positions.
// ---------------------------------------------------------------------------
package lcdmt_pkg;

   // Extra dots spent in pixel transfer, taken back from hblank (0 to 117).
   localparam int TRANSFER_EXTRA = 30;

   localparam int DOT_W   = 9;
   localparam int LINE_W  = 8;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 8;
   localparam int EN_W    = 4;

   // Phase lengths in dots.
   localparam logic [DOT_W-1:0] OAM_DOTS      = DOT_W'(80);
   localparam logic [DOT_W-1:0] TRANSFER_DOTS = DOT_W'(172 + TRANSFER_EXTRA);
   localparam logic [DOT_W-1:0] HBLANK_DOTS   = DOT_W'(204 - TRANSFER_EXTRA);
   localparam logic [DOT_W-1:0] LINE_DOTS     = DOT_W'(456);

   localparam logic [LINE_W-1:0] VISIBLE_LINES = LINE_W'(144);
   localparam logic [LINE_W-1:0] TOTAL_LINES   = LINE_W'(154);

   // Display modes as they appear on the result channel.
   typedef enum logic [1:0] {
      MODE_HBLANK   = 2'd0,
      MODE_VBLANK   = 2'd1,
      MODE_OAM      = 2'd2,
      MODE_TRANSFER = 2'd3
   } lcd_mode_type;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_LINE_COMPARE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_STAT_ENABLES = CSR_IDX_W'(1);

   // Bit positions in the STAT interrupt enable register.
   localparam int EN_HBLANK_BIT = 0;
   localparam int EN_VBLANK_BIT = 1;
   localparam int EN_OAM_BIT    = 2;
   localparam int EN_MATCH_BIT  = 3;

endpackage

@@ hw/rtl/lcd_mode_timing.sv @@
// ---------------------------------------------------------------------------
// lcd_mode_timing: dot-driven display mode sequencer
// Steps OAM scan, pixel transfer, hblank and vblank per dot, tracks the
// line-compare flag and raises STAT, vblank, line-done and frame-done pulses.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  advance
//   rsp_      out        rsp_valid/rsp_ready  mode, line, coincidence, pulses
//   csr_      in         csr_valid/csr_ready  index, data
//
// Every accepted beat produces one result beat in the next cycle; one beat per
// cycle is sustained while results are read, set by the single next-state
// pass from the state registers into the result register. A new beat is
// taken while the result register is empty or is being read in the same
// cycle. Reset is synchronous and returns the sequencer to line 0 in OAM scan
// with registers cleared. The configuration port is always ready.

module lcd_mode_timing (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_advance,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_lcd_mode,
   output logic [lcdmt_pkg::LINE_W-1:0]   rsp_current_line,
   output logic                           rsp_coincidence,
   output logic                           rsp_stat_irq,
   output logic                           rsp_vblank_irq,
   output logic                           rsp_line_done,
   output logic                           rsp_frame_done,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lcdmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcdmt_pkg::CSR_DATA_W-1:0] csr_data
);
   import lcdmt_pkg::*;

   // Configuration registers.
   logic [LINE_W-1:0] line_compare_ff;
   logic [EN_W-1:0]   enables_ff;

   // Sequencer state.
   lcd_mode_type      mode_ff, mode_in;
   logic [DOT_W-1:0]  dot_ff, dot_in, dot_inc;
   logic [LINE_W-1:0] line_ff, line_in, line_inc;
   logic              match_flag_ff, match_flag_in;
   logic              match_fired_ff, match_fired_in;

   // Result register.
   logic              rsp_valid_ff;
   lcd_mode_type      rsp_mode_ff;
   logic [LINE_W-1:0] rsp_line_ff;
   logic              rsp_coin_ff, rsp_stat_ff, rsp_vbl_ff, rsp_ldone_ff, rsp_fdone_ff;

   // Per-dot pulses and the line check request.
   logic              accept;
   logic              stat_src, vblank_pulse, line_pulse, frame_pulse;
   logic              check_en, match_pulse;
   logic [LINE_W-1:0] check_line;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign dot_inc  = dot_ff + DOT_W'(1);
   assign line_inc = line_ff + LINE_W'(1);

   // Mode sequencing: counters, mode edges and the edge-driven STAT sources.
   always_comb begin
      mode_in      = mode_ff;
      dot_in       = dot_ff;
      line_in      = line_ff;
      stat_src     = 1'b0;
      vblank_pulse = 1'b0;
      line_pulse   = 1'b0;
      frame_pulse  = 1'b0;
      check_en     = 1'b0;
      check_line   = line_ff;
      if (req_advance) begin
         dot_in = dot_inc;
         unique case (mode_ff)
            MODE_OAM: begin
               if (dot_inc >= OAM_DOTS) begin
                  dot_in   = '0;
                  mode_in  = MODE_TRANSFER;
                  check_en = 1'b1;
               end
            end
            MODE_TRANSFER: begin
               if (dot_inc >= TRANSFER_DOTS) begin
                  dot_in   = '0;
                  mode_in  = MODE_HBLANK;
                  stat_src = enables_ff[EN_HBLANK_BIT];
                  check_en = 1'b1;
               end
            end
            MODE_HBLANK: begin
               if (dot_inc >= HBLANK_DOTS) begin
                  dot_in     = '0;
                  line_in    = line_inc;
                  line_pulse = 1'b1;
                  check_en   = 1'b1;
                  check_line = line_inc;
                  if (line_inc == VISIBLE_LINES) begin
                     mode_in      = MODE_VBLANK;
                     vblank_pulse = 1'b1;
                     stat_src     = enables_ff[EN_VBLANK_BIT];
                  end else begin
                     mode_in  = MODE_OAM;
                     stat_src = enables_ff[EN_OAM_BIT];
                  end
               end
            end
            MODE_VBLANK: begin
               if (dot_inc >= LINE_DOTS) begin
                  dot_in     = '0;
                  line_in    = line_inc;
                  check_en   = 1'b1;
                  check_line = line_inc;
                  if (line_inc == TOTAL_LINES) begin
                     line_in     = '0;
                     check_line  = '0;
                     mode_in     = MODE_OAM;
                     frame_pulse = 1'b1;
                     stat_src    = enables_ff[EN_OAM_BIT];
                  end
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Line check: the coincidence flag and the one-shot line match interrupt.
   always_comb begin
      match_flag_in  = match_flag_ff;
      match_fired_in = match_fired_ff;
      match_pulse    = 1'b0;
      if (check_en) begin
         if (check_line != line_compare_ff) begin
            match_flag_in  = 1'b0;
            match_fired_in = 1'b0;
         end else begin
            match_flag_in = 1'b1;
            if (enables_ff[EN_MATCH_BIT] && !match_fired_ff) begin
               match_fired_in = 1'b1;
               match_pulse    = 1'b1;
            end
         end
      end
   end

   // Configuration writes; indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_compare_ff <= '0;
         enables_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_LINE_COMPARE) begin
            line_compare_ff <= csr_data;
         end else if (csr_index == REG_STAT_ENABLES) begin
            enables_ff <= csr_data[EN_W-1:0];
         end
      end
   end

   // Sequencer state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_OAM;
         dot_ff         <= '0;
         line_ff        <= '0;
         match_flag_ff  <= 1'b0;
         match_fired_ff <= 1'b0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         dot_ff         <= dot_in;
         line_ff        <= line_in;
         match_flag_ff  <= match_flag_in;
         match_fired_ff <= match_fired_in;
      end
   end

   // Result valid: set on an accepted beat, cleared when the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, loaded with the state after the step.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff  <= mode_in;
         rsp_line_ff  <= line_in;
         rsp_coin_ff  <= match_flag_in;
         rsp_stat_ff  <= stat_src || match_pulse;
         rsp_vbl_ff   <= vblank_pulse;
         rsp_ldone_ff <= line_pulse;
         rsp_fdone_ff <= frame_pulse;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lcd_mode     = rsp_mode_ff;
   assign rsp_current_line = rsp_line_ff;
   assign rsp_coincidence  = rsp_coin_ff;
   assign rsp_stat_irq     = rsp_stat_ff;
   assign rsp_vblank_irq   = rsp_vbl_ff;
   assign rsp_line_done    = rsp_ldone_ff;
   assign rsp_frame_done   = rsp_fdone_ff;

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the display mode sequencer
// Drives dot beats through the request channel, predicts every result beat
// from a local copy of the mode, dot, line and compare state, and checks each
// result field by field under random idling on both sides and whole lines.
// ---------------------------------------------------------------------------
module testbench;
   import lcdmt_pkg::*;

   // Unmapped register indexes; writes to them must leave the block unchanged.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HIGH = '1;

   localparam int STALL_LIMIT = 4000;
   localparam int PRINT_LIMIT = 60;

   // One result beat as the block presents it.
   typedef struct packed {
      lcd_mode_type      mode;
      logic [LINE_W-1:0] line;
      logic              coincidence;
      logic              stat_irq;
      logic              vblank_irq;
      logic              line_done;
      logic              frame_done;
   } dot_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_advance = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_lcd_mode;
   logic [LINE_W-1:0]     rsp_current_line;
   logic                  rsp_coincidence;
   logic                  rsp_stat_irq;
   logic                  rsp_vblank_irq;
   logic                  rsp_line_done;
   logic                  rsp_frame_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predicted sequencer state and register copies.
   lcd_mode_type      seq_mode;
   logic [DOT_W-1:0]  seq_dot;
   logic [LINE_W-1:0] seq_line;
   logic              seq_match;
   logic              seq_fired;
   logic [LINE_W-1:0] cfg_line_cmp;
   logic [EN_W-1:0]   cfg_enables;

   dot_result_type pending_dots[$];
   int          mismatch_count = 0;
   int          results_seen = 0;
   int          stall_cycles = 0;
   int          src_idle_pct = 0;
   int          sink_idle_pct = 0;
   int          hold_len = 0;
   int          hold_serial = 0;

   lcd_mode_timing u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_advance      (req_advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lcd_mode     (rsp_lcd_mode),
      .rsp_current_line (rsp_current_line),
      .rsp_coincidence  (rsp_coincidence),
      .rsp_stat_irq     (rsp_stat_irq),
      .rsp_vblank_irq   (rsp_vblank_irq),
      .rsp_line_done    (rsp_line_done),
      .rsp_frame_done   (rsp_frame_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Clock with a period of 12.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Line check: updates the coincidence flag and returns a line-match STAT pulse.
   function automatic logic compare_line();
      if (seq_line != cfg_line_cmp) begin
         seq_match = 1'b0;
         seq_fired = 1'b0;
         return 1'b0;
      end
      seq_match = 1'b1;
      if (cfg_enables[EN_MATCH_BIT] && !seq_fired) begin
         seq_fired = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Steps the predicted sequencer by one beat and returns the result it causes.
   function automatic dot_result_type advance_dot(input logic adv);
      dot_result_type r;
      r = '0;
      if (adv) begin
         seq_dot = seq_dot + 1'b1;
         case (seq_mode)
            MODE_OAM: begin
               if (seq_dot >= OAM_DOTS) begin
                  seq_dot = '0;
                  seq_mode = MODE_TRANSFER;
                  r.stat_irq |= compare_line();
               end
            end
            MODE_TRANSFER: begin
               if (seq_dot >= TRANSFER_DOTS) begin
                  r.stat_irq = cfg_enables[EN_HBLANK_BIT];
                  seq_dot = '0;
                  seq_mode = MODE_HBLANK;
                  r.stat_irq |= compare_line();
               end
            end
            MODE_HBLANK: begin
               if (seq_dot >= HBLANK_DOTS) begin
                  r.line_done = 1'b1;
                  seq_line = seq_line + 1'b1;
                  seq_dot = '0;
                  r.stat_irq |= compare_line();
                  if (seq_line == VISIBLE_LINES) begin
                     seq_mode = MODE_VBLANK;
                     r.vblank_irq = 1'b1;
                     if (cfg_enables[EN_VBLANK_BIT]) r.stat_irq = 1'b1;
                  end else begin
                     seq_mode = MODE_OAM;
                     if (cfg_enables[EN_OAM_BIT]) r.stat_irq = 1'b1;
                  end
               end
            end
            default: begin
               if (seq_dot >= LINE_DOTS) begin
                  seq_line = seq_line + 1'b1;
                  seq_dot = '0;
                  if (seq_line == TOTAL_LINES) begin
                     r.frame_done = 1'b1;
                     seq_line = '0;
                     seq_mode = MODE_OAM;
                     if (cfg_enables[EN_OAM_BIT]) r.stat_irq = 1'b1;
                  end
                  r.stat_irq |= compare_line();
               end
            end
         endcase
      end
      r.mode = seq_mode;
      r.line = seq_line;
      r.coincidence = seq_match;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at result %0d, %s: got %0d, wanted %0d",
                  results_seen, field, got, want);
   endtask

   // Offers one dot beat after a random gap and records its predicted result.
   task automatic send_dot(input logic adv);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_advance <= adv;
      do @(posedge clock); while (!req_ready);
      pending_dots.push_back(advance_dot(adv));
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_dots.size() != 0);
   endtask

   // Register write beat; back-to-back writes keep csr_valid high.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_LINE_COMPARE) cfg_line_cmp = val[LINE_W-1:0];
      else if (idx == REG_STAT_ENABLES) cfg_enables = val[EN_W-1:0];
   endtask

   // Rewrites both registers once the block has gone idle.
   task automatic set_regs(input logic [CSR_DATA_W-1:0] line_cmp,
                           input logic [CSR_DATA_W-1:0] enables);
      drain_results();
      write_reg(REG_LINE_COMPARE, line_cmp);
      write_reg(REG_STAT_ENABLES, enables);
      csr_valid <= 1'b0;
   endtask

   // Compare values lean toward lines that the run actually reaches.
   function automatic logic [CSR_DATA_W-1:0] pick_line_compare();
      case ($urandom_range(6))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_W'(TOTAL_LINES - 1'b1);
         3: return CSR_DATA_W'(VISIBLE_LINES);
         4: return CSR_DATA_W'($urandom_range(4));
         default: return CSR_DATA_W'($urandom_range(153));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_enables();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return CSR_DATA_W'($urandom_range(255));
      endcase
   endfunction

   // Idle steps right after reset, then a few dots.
   task automatic test_idle_steps();
      repeat (3) send_dot(1'b0);
      repeat (4) send_dot(1'b1);
      repeat (2) send_dot(1'b0);
   endtask

   // Extreme values, over-wide enable data and writes to unmapped indexes.
   task automatic test_register_writes();
      drain_results();
      write_reg(REG_LINE_COMPARE, '1);
      write_reg(REG_STAT_ENABLES, '1);
      write_reg(REG_UNMAPPED_LOW, '0);
      write_reg(REG_UNMAPPED_HIGH, '0);
      csr_valid <= 1'b0;
      repeat (8) send_dot(1'b1);
      set_regs('0, '0);
      repeat (2) send_dot(1'b0);
      repeat (2) send_dot(1'b1);
   endtask

   // Short mixed runs of idle and advancing dots with fresh settings between.
   task automatic test_random_dots(input int count);
      int sent;
      int chunk;
      sent = 0;
      while (sent < count) begin
         chunk = $urandom_range(60, 180);
         repeat (chunk) send_dot($urandom_range(99) >= 15);
         sent += chunk;
         set_regs(pick_line_compare(), pick_enables());
      end
   endtask

   // Whole lines of mostly advancing dots, settings rewritten between chunks.
   task automatic test_line_walk(input int lines);
      int dots;
      int chunk;
      logic adv;
      dots = 0;
      while (dots < lines * int'(LINE_DOTS)) begin
         chunk = $urandom_range(100, 200);
         repeat (chunk) begin
            adv = ($urandom_range(99) >= 3);
            send_dot(adv);
            if (adv) dots++;
         end
         set_regs(pick_line_compare(), pick_enables());
      end
   endtask

   // Long receiver hold-off so the block fills, then a full sender pause.
   task automatic test_backpressure();
      hold_len = 300;
      hold_serial++;
      repeat (40) send_dot(1'b1);
      drain_results();
      repeat (40) send_dot(1'($urandom_range(1)));
   endtask

   // Receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      int hold_seen;
      int hold_left;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_serial) begin
         hold_seen = hold_serial;
         hold_left = hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Result checker: each accepted beat against the oldest prediction.
   always @(posedge clock) begin
      dot_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_dots.size() == 0) begin
            report_mismatch("beat with nothing predicted", 1, 0);
         end else begin
            want = pending_dots.pop_front();
            if (rsp_lcd_mode !== want.mode)
               report_mismatch("lcd_mode", rsp_lcd_mode, want.mode);
            if (rsp_current_line !== want.line)
               report_mismatch("current_line", rsp_current_line, want.line);
            if (rsp_coincidence !== want.coincidence)
               report_mismatch("coincidence", rsp_coincidence, want.coincidence);
            if (rsp_stat_irq !== want.stat_irq)
               report_mismatch("stat_irq", rsp_stat_irq, want.stat_irq);
            if (rsp_vblank_irq !== want.vblank_irq)
               report_mismatch("vblank_irq", rsp_vblank_irq, want.vblank_irq);
            if (rsp_line_done !== want.line_done)
               report_mismatch("line_done", rsp_line_done, want.line_done);
            if (rsp_frame_done !== want.frame_done)
               report_mismatch("frame_done", rsp_frame_done, want.frame_done);
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      seq_mode = MODE_OAM;
      seq_dot = '0;
      seq_line = '0;
      seq_match = 1'b0;
      seq_fired = 1'b0;
      cfg_line_cmp = '0;
      cfg_enables = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_steps();
      test_register_writes();

      src_idle_pct = 27;
      sink_idle_pct = 65;
      test_random_dots(300);
      test_line_walk(1);

      src_idle_pct = 65;
      sink_idle_pct = 27;
      test_random_dots(300);
      test_line_walk(1);

      src_idle_pct = 0;
      sink_idle_pct = 0;
      test_backpressure();

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/lcdmt_pkg.sv
hw/rtl/lcd_mode_timing.sv
tb/testbench.sv
